// ----- rtl/sbcp_pkg.sv -----
`default_nettype none

package sbcp_pkg;

    // Coordinate width of every field.
    localparam int COORD_BITS = 32;
    // Width of an edge difference, which can reach twice the coordinate range.
    localparam int DIFF_BITS = COORD_BITS + 1;
    // Width of a product of a difference magnitude and a velocity magnitude.
    localparam int PROD_BITS = DIFF_BITS + COORD_BITS;
    // Dividend width after the rounding half is added.
    localparam int DVD_BITS = PROD_BITS + 1;
    // One quotient bit is produced by each divider stage.
    localparam int DIV_STEPS = COORD_BITS;
    // Pipeline delay from an accepted word to its result strobe.
    localparam int LATENCY = DIV_STEPS + 5;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] a_left;
        logic signed [COORD_BITS-1:0] a_right;
        logic signed [COORD_BITS-1:0] a_bottom;
        logic signed [COORD_BITS-1:0] a_top;
        logic signed [COORD_BITS-1:0] vel_x;
        logic signed [COORD_BITS-1:0] vel_y;
        logic signed [COORD_BITS-1:0] b_left;
        logic signed [COORD_BITS-1:0] b_right;
        logic signed [COORD_BITS-1:0] b_bottom;
        logic signed [COORD_BITS-1:0] b_top;
    } t_in;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] push_x;
        logic signed [COORD_BITS-1:0] push_y;
        logic                         hit;
    } t_out;

    // Side information that rides along the divider stages.
    typedef struct packed {
        logic                         hit;
        logic                         pass;
        logic                         vert;
        logic                         neg;
        logic                         sat;
        logic signed [COORD_BITS-1:0] pass_x;
        logic signed [COORD_BITS-1:0] pass_y;
        logic signed [COORD_BITS-1:0] other;
    } t_side;

    // Saturate a difference to the signed coordinate range.
    function automatic logic signed [COORD_BITS-1:0] clamp_diff(
        input logic signed [DIFF_BITS-1:0] v
    );
        logic signed [COORD_BITS-1:0] res;
        if (v[DIFF_BITS-1] != v[DIFF_BITS-2]) begin
            res = v[DIFF_BITS-1] ? {1'b1, {(COORD_BITS-1){1'b0}}}
                                 : {1'b0, {(COORD_BITS-1){1'b1}}};
        end else begin
            res = v[COORD_BITS-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/swept_box_collision_push.sv -----
`default_nettype none

// Swept box collision push.
// A word on i_data (moving box A, its velocity, fixed box B, all signed
// Q16.16) is accepted at a rising edge where i_start is high and o_busy is
// low. o_busy is always low: the block takes a new word in every cycle.
// Each word produces exactly one result word on o_data, marked by o_valid for
// a single cycle, in acceptance order. The receiver cannot stall, and the
// block needs no back pressure because every stage advances in every cycle.
// The pipeline has four setup stages (edge differences, two products, the
// compare and rounding add, the saturation test), then one restoring divider
// stage per quotient bit (32 stages), then the output register. The divider
// depth sets the latency; throughput is one word per cycle.
// Synchronous active-low reset clears all valid bits; words in flight are
// dropped and o_valid stays low until new words arrive.
// A result with hit low carries a zero push vector.
module swept_box_collision_push (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire sbcp_pkg::t_in i_data,
    output logic               o_busy,
    output logic               o_valid,
    output sbcp_pkg::t_out     o_data
);

    localparam int CW = sbcp_pkg::COORD_BITS;
    localparam int DW = sbcp_pkg::DIFF_BITS;
    localparam int PW = sbcp_pkg::PROD_BITS;
    localparam int VW = sbcp_pkg::DVD_BITS;
    localparam int NS = sbcp_pkg::DIV_STEPS;

    assign o_busy = 1'b0;

    // Stage 1: overlap test, leading corner, near edges, differences.
    logic                 r1_vld, r1_hit, r1_vx0, r1_vy0, r1_svx, r1_svy;
    logic signed [DW-1:0] r1_dx, r1_dy;
    logic [CW-1:0]        r1_mvx, r1_mvy;
    logic signed [DW-1:0] n1_dx, n1_dy;
    logic                 n1_hit;

    always_comb begin
        logic signed [CW-1:0] cx, cy, ex, ey;
        logic px, py;
        px = i_data.vel_x > 0;
        py = i_data.vel_y > 0;
        cx = px ? i_data.a_right : i_data.a_left;
        cy = py ? i_data.a_top : i_data.a_bottom;
        ex = px ? i_data.b_left : i_data.b_right;
        ey = py ? i_data.b_bottom : i_data.b_top;
        n1_dx = DW'(ex) - DW'(cx);
        n1_dy = DW'(ey) - DW'(cy);
        n1_hit = !(i_data.a_left >= i_data.b_right || i_data.a_right <= i_data.b_left ||
                   i_data.a_bottom >= i_data.b_top || i_data.a_top <= i_data.b_bottom ||
                   (i_data.vel_x == '0 && i_data.vel_y == '0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= i_start;
        end
        r1_hit <= n1_hit;
        r1_dx  <= n1_dx;
        r1_dy  <= n1_dy;
        r1_vx0 <= i_data.vel_x == '0;
        r1_vy0 <= i_data.vel_y == '0;
        r1_svx <= i_data.vel_x[CW-1];
        r1_svy <= i_data.vel_y[CW-1];
        r1_mvx <= i_data.vel_x[CW-1] ? CW'(-i_data.vel_x) : CW'(i_data.vel_x);
        r1_mvy <= i_data.vel_y[CW-1] ? CW'(-i_data.vel_y) : CW'(i_data.vel_y);
    end

    // Stage 2: cross products that order the two cuts; clamped differences.
    logic                 r2_vld, r2_hit, r2_vx0, r2_vy0, r2_sx, r2_sy;
    logic [PW-1:0]        r2_p1, r2_p2;
    logic [CW-1:0]        r2_mvx, r2_mvy;
    logic signed [CW-1:0] r2_cdx, r2_cdy;
    logic [DW-1:0]        n2_mdx, n2_mdy;

    assign n2_mdx = r1_dx[DW-1] ? DW'(-r1_dx) : DW'(r1_dx);
    assign n2_mdy = r1_dy[DW-1] ? DW'(-r1_dy) : DW'(r1_dy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
        r2_hit <= r1_hit;
        r2_vx0 <= r1_vx0;
        r2_vy0 <= r1_vy0;
        r2_p1  <= PW'(n2_mdx) * PW'(r1_mvy);
        r2_p2  <= PW'(n2_mdy) * PW'(r1_mvx);
        r2_mvx <= r1_mvx;
        r2_mvy <= r1_mvy;
        r2_sx  <= r1_dx[DW-1] ^ r1_svy ^ r1_svx;
        r2_sy  <= r1_dy[DW-1] ^ r1_svx ^ r1_svy;
        r2_cdx <= sbcp_pkg::clamp_diff(r1_dx);
        r2_cdy <= sbcp_pkg::clamp_diff(r1_dy);
    end

    // Stage 3: pick the nearer cut (ties to the vertical edge), add the
    // rounding half to the chosen product.
    logic                 r3_vld;
    sbcp_pkg::t_side      r3_side;
    logic [VW-1:0]        r3_dvd;
    logic [CW-1:0]        r3_den;
    sbcp_pkg::t_side      n3_side;
    logic [CW-1:0]        n3_den;
    logic [PW-1:0]        n3_prod;

    always_comb begin
        n3_side.hit  = r2_hit;
        n3_side.pass = r2_vx0 || r2_vy0;
        n3_side.vert = r2_p1 <= r2_p2;
        n3_side.neg  = n3_side.vert ? r2_sx : r2_sy;
        n3_side.sat  = 1'b0;
        n3_side.pass_x = r2_vy0 ? r2_cdx : '0;
        n3_side.pass_y = r2_vy0 ? '0 : r2_cdy;
        n3_side.other  = n3_side.vert ? r2_cdx : r2_cdy;
        n3_den  = n3_side.vert ? r2_mvx : r2_mvy;
        n3_prod = n3_side.vert ? r2_p1 : r2_p2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else begin
            r3_vld <= r2_vld;
        end
        r3_side <= n3_side;
        r3_den  <= n3_den;
        r3_dvd  <= VW'(n3_prod) + VW'(n3_den >> 1);
    end

    // Stage 4: saturation test. The quotient exceeds its limit exactly when
    // the dividend reaches (limit + 1) times the divisor.
    logic          r_vld  [0:NS];
    sbcp_pkg::t_side r_side [0:NS];
    logic [CW-1:0] r_den  [0:NS];
    logic [CW-1:0] r_rem  [0:NS];
    logic [CW-1:0] r_low  [0:NS];
    logic [CW-1:0] r_quo  [0:NS];
    logic [VW-1:0] n4_thr;
    sbcp_pkg::t_side n4_side;

    always_comb begin
        n4_thr = (VW'(r3_den) << (CW - 1)) + (r3_side.neg ? VW'(r3_den) : VW'(0));
        n4_side = r3_side;
        n4_side.sat = r3_dvd >= n4_thr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= r3_vld;
        end
        r_side[0] <= n4_side;
        r_den[0]  <= r3_den;
        r_rem[0]  <= r3_dvd[2*CW-1:CW];
        r_low[0]  <= r3_dvd[CW-1:0];
        r_quo[0]  <= '0;
    end

    // Divider: one restoring step, one quotient bit, per stage.
    for (genvar k = 0; k < NS; k++) begin : g_div
        logic [CW:0] trial;
        logic        ge;
        assign trial = {r_rem[k], r_low[k][CW-1]};
        assign ge    = trial >= {1'b0, r_den[k]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else begin
                r_vld[k+1] <= r_vld[k];
            end
            r_side[k+1] <= r_side[k];
            r_den[k+1]  <= r_den[k];
            r_rem[k+1]  <= ge ? CW'(trial - {1'b0, r_den[k]}) : trial[CW-1:0];
            r_low[k+1]  <= r_low[k] << 1;
            r_quo[k+1]  <= {r_quo[k][CW-2:0], ge};
        end
    end

    // Output stage: apply saturation and sign, place the components.
    sbcp_pkg::t_out r_out;
    logic           r_out_vld;
    sbcp_pkg::t_out n_out;

    always_comb begin
        logic [CW-1:0]        lim, q;
        logic signed [CW-1:0] sv;
        sbcp_pkg::t_side      sd;
        sd  = r_side[NS];
        lim = sd.neg ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
        q   = sd.sat ? lim : r_quo[NS];
        sv  = sd.neg ? CW'(-q) : q;
        n_out.hit = sd.hit;
        if (!sd.hit) begin
            n_out.push_x = '0;
            n_out.push_y = '0;
        end else if (sd.pass) begin
            n_out.push_x = sd.pass_x;
            n_out.push_y = sd.pass_y;
        end else if (sd.vert) begin
            n_out.push_x = sd.other;
            n_out.push_y = sv;
        end else begin
            n_out.push_x = sv;
            n_out.push_y = sd.other;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_vld[NS];
        end
        r_out <= n_out;
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

    // Checks.
    a_never_busy: assert property (@(posedge i_clk) !o_busy)
        else $error("busy raised");
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_data.hit) |-> (o_data.push_x == '0 && o_data.push_y == '0))
        else $error("miss with nonzero push");
    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result strobe after reset");
    a_div_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NS] |=> o_valid)
        else $error("divider result lost");
    a_pass_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NS] && r_side[NS].hit && r_side[NS].pass) |=>
        (o_data.push_x == '0 || o_data.push_y == '0))
        else $error("axis-aligned push has two components");

endmodule

`default_nettype wire
